[hw/rtl/tat_pkg.sv]
// Shared types, constants and the arctangent table for the tilt angle unit.
`default_nettype none

package tat_pkg;

  // Angle accumulator width, in 1/65536 degree, with sign and headroom.
  localparam int ZW          = 26;
  localparam int ATAN_W      = 22;
  localparam int IDX_W       = 5;
  localparam int TABLE_LEN   = 24;
  localparam int TILT_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int ANGLE_MAX   = 23040;
  localparam int ROUND_HALF  = 128;
  localparam int FRAC_DROP   = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 15'd1280;
  localparam logic               REG_TILT_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_ROT_GO,
    ST_ROT_WAIT,
    ST_FINISH
  } tat_state_e;

  // atan(2^-i) in degrees times 65536, rounded.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/accel_tilt_angle_warning_unit.sv]
// Top level of the accelerometer tilt angle and warning unit.
// A valid sample takes both angles through the square root and CORDIC units in turn; an
// invalid one goes straight to the result register. No new sample is taken until then.
// The square root and CORDIC units are shared by both angles and each resolves one bit or
// one rotation per cycle.
// Reset clears the held angles and the sequencer and sets tilt_limit to 5 degrees.
`default_nettype none

module accel_tilt_angle_warning_unit import tat_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // accel_x, accel_y, accel_z from the lowest bit up, zero padded to bytes.
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // sample_valid.
  input  wire logic [0:0]                               s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // tilt_x, tilt_y from the lowest bit up.
  output logic [2*TILT_W-1:0]                           m_axis_tdata,
  // tilt_valid, warning from the lowest bit up.
  output logic [1:0]                                    m_axis_tuser,
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [PADDR_W-1:0]                       paddr,
  input  wire logic [PDATA_W-1:0]                       pwdata,
  output logic [PDATA_W-1:0]                            prdata,
  output logic                                          pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SQW   = 2 * SB;
  localparam int RADW  = SQW + 16;
  localparam int ROOTW = RADW / 2;
  localparam int XW    = SB + 12;

  tat_state_e state_q, state_d;

  logic signed [SB-1:0]     ax_q, ay_q, az_q;
  logic                     valid_q;
  logic                     sel_q;
  logic [SQW-1:0]           acc_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic signed [TILT_W-1:0] held_x_q, held_y_q;

  logic signed [TILT_W-1:0] out_tx_q, out_ty_q;
  logic                     out_vld_q, out_warn_q, m_valid_q;

  logic                     accept;
  logic                     out_load;
  logic                     sqrt_start, sqrt_done;
  logic                     rot_start, rot_done;
  logic [ROOTW-1:0]         root;
  logic signed [TILT_W-1:0] angle;

  logic signed [SB-1:0]     a_sel, mul_op;
  logic signed [SQW-1:0]    prod;
  logic signed [SB:0]       num;
  logic signed [XW-1:0]     x0, y0;
  logic [TILT_W-1:0]        abs_x, abs_y;
  logic                     warn;
  logic                     cfg_wr;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Operand selection: the first angle uses (ay; ax, az), the second (-ax; ay, az).
  assign a_sel  = sel_q ? ay_q : ax_q;
  assign mul_op = (state_q == ST_SQ_A) ? a_sel : az_q;
  assign prod   = mul_op * mul_op;
  assign num    = sel_q ? -{ax_q[SB-1], ax_q} : {ay_q[SB-1], ay_q};
  assign x0     = {{(XW-ROOTW){1'b0}}, root};
  assign y0     = {{(XW-SB-9){num[SB]}}, num, 8'h00};

  tat_sqrt #(.RW(RADW)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({acc_q, 16'h0000}),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  tat_cordic #(.XW(XW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .x0_i    (x0),
    .y0_i    (y0),
    .angle_o (angle),
    .done_o  (rot_done)
  );

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    sqrt_start    = 1'b0;
    rot_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = s_axis_tuser[0] ? ST_SQ_A : ST_FINISH;
        end
      end
      ST_SQ_A:    state_d = ST_SQ_B;
      ST_SQ_B:    state_d = ST_ROOT_GO;
      ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_done) begin
          state_d = ST_ROT_GO;
        end
      end
      ST_ROT_GO: begin
        rot_start = 1'b1;
        state_d   = ST_ROT_WAIT;
      end
      ST_ROT_WAIT: begin
        if (rot_done) begin
          state_d = sel_q ? ST_FINISH : ST_SQ_A;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q    <= s_axis_tdata[SB-1:0];
      ay_q    <= s_axis_tdata[2*SB-1:SB];
      az_q    <= s_axis_tdata[3*SB-1:2*SB];
      valid_q <= s_axis_tuser[0];
    end
    if (state_q == ST_SQ_A) begin
      acc_q <= $unsigned(prod);
    end else if (state_q == ST_SQ_B) begin
      acc_q <= acc_q + $unsigned(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= 1'b0;
      held_x_q <= '0;
      held_y_q <= '0;
    end else begin
      if (accept) begin
        sel_q <= 1'b0;
      end else if (state_q == ST_ROT_WAIT && rot_done) begin
        sel_q <= 1'b1;
        if (sel_q) begin
          held_y_q <= angle;
        end else begin
          held_x_q <= angle;
        end
      end
    end
  end

  assign abs_x = held_x_q[TILT_W-1] ? -held_x_q : held_x_q;
  assign abs_y = held_y_q[TILT_W-1] ? -held_y_q : held_y_q;
  assign warn  = valid_q && ((abs_x > {1'b0, limit_q}) || (abs_y > {1'b0, limit_q}));

  // Result register: a finished result waits here while the next sample is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tx_q   <= held_x_q;
      out_ty_q   <= held_y_q;
      out_vld_q  <= valid_q;
      out_warn_q <= warn;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_ty_q, out_tx_q};
  assign m_axis_tuser  = {out_warn_q, out_vld_q};

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TILT_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TILT_LIMIT) ? {{(PDATA_W-LIMIT_W){1'b0}}, limit_q} : '0;

  // The sequencer leaves idle on every accepted sample.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_warn_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
    else $error("warning raised on an invalid sample");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd23040 &&
                       $signed(m_axis_tdata[31:16]) <= 16'sd23040 &&
                       $signed(m_axis_tdata[31:16]) >= -16'sd23040))
    else $error("tilt angle out of range");

  a_result_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("finished result not presented");

endmodule

`default_nettype wire

[hw/rtl/tat_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module tat_sqrt import tat_pkg::*; #(
  parameter int RW = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RW-1:0]      radicand_i,
  output logic      [RW/2-1:0]    root_o,
  output logic                    done_o
);

  localparam int N  = RW / 2;
  localparam int CW = $clog2(N);

  logic [RW-1:0] rad_q, rad_d;
  logic [N:0]    rem_q, rem_d;
  logic [N-1:0]  root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [N+1:0]  rem_sh;
  logic [N+1:0]  trial;
  logic [N+1:0]  rem_sub;

  assign rem_sh  = {rem_q[N-1:0], rad_q[RW-1:RW-2]};
  assign trial   = {root_q, 2'b01};
  assign rem_sub = rem_sh - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sub[N:0];
        root_d = {root_q[N-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[N:0];
        root_d = {root_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/tat_cordic.sv]
// Iterative CORDIC vectoring unit that returns atan2(y, x) in 1/256 degree.
`default_nettype none

module tat_cordic import tat_pkg::*; #(
  parameter int XW    = 28,
  parameter int STEPS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [XW-1:0]     x0_i,
  input  wire logic signed [XW-1:0]     y0_i,
  output logic signed      [TILT_W-1:0] angle_o,
  output logic                          done_o
);

  localparam int NSTEP = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  localparam logic signed [ZW-1:0] ZMAX = ZW'(ANGLE_MAX);

  logic signed [XW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [XW-1:0]  dx, dy;
  logic signed [ZW-1:0]  z_q, z_d;
  logic signed [ZW-1:0]  atan_z;
  logic signed [ZW-1:0]  z_rnd;
  logic [IDX_W-1:0]      i_q, i_d;
  logic                  zero_q, zero_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  assign dx     = y_q >>> i_q;
  assign dy     = x_q >>> i_q;
  assign atan_z = {{(ZW-ATAN_W){1'b0}}, atan_lut(i_q)};

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    zero_d = zero_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x0_i;
      y_d    = y0_i;
      z_d    = '0;
      i_d    = '0;
      zero_d = (y0_i == '0);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_z;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_z;
      end
      i_d = i_q + 1'b1;
      if (i_q == IDX_W'(NSTEP - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  // Round half up to 1/256 degree, then clamp to plus or minus 90 degrees; a zero y input gives zero.
  assign z_rnd = (z_q + ZW'(ROUND_HALF)) >>> FRAC_DROP;

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (z_rnd > ZMAX) begin
      angle_o = ZMAX[TILT_W-1:0];
    end else if (z_rnd < -ZMAX) begin
      angle_o = TILT_W'(-ZMAX);
    end else begin
      angle_o = z_rnd[TILT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[dv/tb_accel_tilt_angle_warning_unit.sv]
// Self-checking testbench for the accelerometer tilt angle and warning unit.
module tb_accel_tilt_angle_warning_unit import tat_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = 16;
  localparam int STEPS       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;
  localparam int LONG_STALL  = 600;
  localparam int SETTLE      = 200;
  localparam int CYCLE_LIMIT = 1200000;

  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * int'(REG_TILT_LIMIT));
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * (int'(REG_TILT_LIMIT) + 1));

  typedef struct packed {
    logic signed [SB-1:0] ax;
    logic signed [SB-1:0] ay;
    logic signed [SB-1:0] az;
    logic                 ok;
  } sample_t;

  typedef struct {
    logic signed [TILT_W-1:0] tx;
    logic signed [TILT_W-1:0] ty;
    logic                     tv;
    logic                     warn;
  } tilt_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // accel_x, accel_y, accel_z from the lowest bit up.
  logic [((3*SB+7)/8)*8-1:0] s_axis_tdata;
  // sample_valid.
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // tilt_x, tilt_y from the lowest bit up.
  logic [2*TILT_W-1:0] m_axis_tdata;
  // tilt_valid, warning from the lowest bit up.
  logic [1:0] m_axis_tuser;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // atan(2^-i) in 1/65536 degree.
  longint atan_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  sample_t             sample_q [$];
  tilt_t               tilt_q [$];
  sample_t             cur_sample;
  logic [LIMIT_W-1:0]  limit_reg;
  logic signed [15:0]  held_x;
  logic signed [15:0]  held_y;
  bit                  src_busy;
  bit                  src_steady;
  bit                  sink_steady;
  bit                  stall_req;
  int                  stall_left;
  int                  issued_n;
  int                  accepted_n;
  int                  errors;
  int                  cycles;
  int                  n_checked;
  int                  n_warned;
  int                  n_held;

  accel_tilt_angle_warning_unit #(
    .CORDIC_STEPS(STEPS),
    .SAMPLE_BITS (SB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // atan2(num, sqrt(a^2 + b^2)) by CORDIC vectoring, in 1/256 degree.
  function automatic logic signed [15:0] tilt_of(longint num, longint a, longint b);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = longint'(int_sqrt(longint'(a * a + b * b) << 16));
    y = num * 256;
    z = 0;
    if (y == 0) return '0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_deg[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_deg[i];
      end
    end
    z = (z + ROUND_HALF) >>> FRAC_DROP;
    if (z > ANGLE_MAX) z = ANGLE_MAX;
    if (z < -ANGLE_MAX) z = -ANGLE_MAX;
    return 16'(z);
  endfunction

  function automatic void predict_tilt(sample_t s);
    tilt_t  t;
    longint abs_x;
    longint abs_y;
    t.warn = 1'b0;
    if (s.ok) begin
      held_x = tilt_of(longint'(s.ay), longint'(s.ax), longint'(s.az));
      held_y = tilt_of(-longint'(s.ax), longint'(s.ay), longint'(s.az));
      abs_x  = held_x < 0 ? -longint'(held_x) : longint'(held_x);
      abs_y  = held_y < 0 ? -longint'(held_y) : longint'(held_y);
      t.warn = (abs_x > longint'(limit_reg)) || (abs_y > longint'(limit_reg));
    end
    t.tx = held_x;
    t.ty = held_y;
    t.tv = s.ok;
    tilt_q.push_back(t);
  endfunction

  function automatic int edge_value();
    int v;
    case ($urandom_range(4))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = 0;
      3:       v = -1;
      default: v = 1;
    endcase
    return v;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      mag;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        s.ax = 16'($urandom);
        s.ay = 16'($urandom);
        s.az = 16'($urandom);
      end
      4, 5: begin
        s.ax = 16'($urandom_range(600) - 300);
        s.ay = 16'($urandom_range(600) - 300);
        s.az = 16'($urandom_range(600) - 300);
      end
      6, 7: begin
        // Near level: small x and y against a large z, so the warning limit matters.
        mag  = $urandom_range(32767, 10000);
        s.ax = 16'($urandom_range(4000) - 2000);
        s.ay = 16'($urandom_range(4000) - 2000);
        s.az = 16'($urandom_range(1) ? -mag : mag);
      end
      8: begin
        s.ax = 16'(edge_value());
        s.ay = 16'(edge_value());
        s.az = 16'(edge_value());
      end
      default: begin
        s.ax = $urandom_range(1) ? 16'($urandom) : 16'd0;
        s.ay = $urandom_range(1) ? 16'($urandom) : 16'd0;
        s.az = $urandom_range(1) ? 16'($urandom) : 16'd0;
      end
    endcase
    s.ok = $urandom_range(99) < 85;
    return s;
  endfunction

  function automatic sample_t mk(int x, int y, int z, logic ok);
    sample_t s;
    s.ax = 16'(x);
    s.ay = 16'(y);
    s.az = 16'(z);
    s.ok = ok;
    return s;
  endfunction

  // Sender: holds each transaction until it is accepted.
  always @(negedge clk_i) begin
    if (rst_ni && !src_busy) begin
      if (sample_q.size() > 0 && (src_steady || $urandom_range(99) >= 29)) begin
        cur_sample = sample_q.pop_front();
        src_busy   = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_sample.az, cur_sample.ay, cur_sample.ax};
        s_axis_tuser  <= cur_sample.ok;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 48'({$urandom, $urandom});
        s_axis_tuser  <= 1'($urandom_range(1));
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_steady || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_req) begin
      stall_left <= LONG_STALL;
      stall_req = 1'b0;
    end
  end

  // Checks results against the predicted queue, then records new input transactions.
  always @(posedge clk_i) begin
    tilt_t                    e;
    logic signed [TILT_W-1:0] tx;
    logic signed [TILT_W-1:0] ty;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tx = m_axis_tdata[TILT_W-1:0];
        ty = m_axis_tdata[2*TILT_W-1:TILT_W];
        if (tilt_q.size() == 0) begin
          $error("result with nothing pending: tilt_x %0d tilt_y %0d", tx, ty);
          errors++;
        end else begin
          e = tilt_q.pop_front();
          if (tx !== e.tx) begin
            $error("tilt_x expected %0d actual %0d", e.tx, tx);
            errors++;
          end
          if (ty !== e.ty) begin
            $error("tilt_y expected %0d actual %0d", e.ty, ty);
            errors++;
          end
          if (m_axis_tuser[0] !== e.tv) begin
            $error("tilt_valid expected %0b actual %0b", e.tv, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== e.warn) begin
            $error("warning expected %0b actual %0b", e.warn, m_axis_tuser[1]);
            errors++;
          end
          n_checked++;
          if (e.warn) n_warned++;
          if (!e.tv) n_held++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tilt(cur_sample);
        src_busy = 1'b0;
        accepted_n++;
      end
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) limit_reg = val;
  endtask

  task automatic apb_check_limit();
    logic [PDATA_W-1:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[LIMIT_W-1:0] !== limit_reg) begin
      $error("tilt_limit expected %0d actual %0d", limit_reg, rd[LIMIT_W-1:0]);
      errors++;
    end
  endtask

  task automatic wait_drained();
    while (accepted_n != issued_n || tilt_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic queue_sample(input sample_t s);
    sample_q.push_back(s);
    issued_n++;
  endtask

  initial begin
    int limit_plan [PHASES];
    limit_plan = '{0, ANGLE_MAX, 1280, 2560, 64, 0, 0, 0};
    limit_plan[5] = $urandom_range(ANGLE_MAX);
    limit_plan[6] = $urandom_range(ANGLE_MAX - 1, 1);
    limit_plan[7] = ANGLE_MAX - 1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    limit_reg     = LIMIT_RESET;
    held_x        = '0;
    held_y        = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    apb_check_limit();

    // Extremes, zero arguments, vertical axes and held angles, at the reset limit.
    queue_sample(mk(0, 0, 0, 1'b1));
    queue_sample(mk(0, 0, 0, 1'b0));
    queue_sample(mk(32767, 0, 0, 1'b1));
    queue_sample(mk(-32768, 0, 0, 1'b1));
    queue_sample(mk(0, 32767, 0, 1'b1));
    queue_sample(mk(0, -32768, 0, 1'b1));
    queue_sample(mk(-12345, 321, 999, 1'b0));
    queue_sample(mk(0, 0, 32767, 1'b1));
    queue_sample(mk(0, 0, -32768, 1'b1));
    queue_sample(mk(-32768, -32768, -32768, 1'b1));
    queue_sample(mk(32767, 32767, 32767, 1'b1));
    queue_sample(mk(-1, -1, -1, 1'b0));
    queue_sample(mk(1, 1, 1, 1'b1));
    queue_sample(mk(-1, 0, 0, 1'b1));
    queue_sample(mk(0, 1, 0, 1'b1));
    queue_sample(mk(-32768, 32767, 0, 1'b1));
    queue_sample(mk(200, -150, 16384, 1'b1));
    queue_sample(mk(-400, 300, -16384, 1'b1));
    queue_sample(mk(32767, -32768, 1, 1'b0));
    queue_sample(mk(100, 100, 1, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      apb_write(LIMIT_ADDR, LIMIT_W'(limit_plan[p]));
      // A write to an unmapped address must leave the limit alone.
      if (p == 4) apb_write(SPARE_ADDR, LIMIT_W'($urandom));
      apb_check_limit();
      src_steady  = (p == 2) || (p == 3);
      sink_steady = (p == 2);
      // The receiver stalls for a long stretch while the sender keeps offering.
      if (p == 3) stall_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(random_sample());
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("Checked %0d results (%0d with warning, %0d from invalid samples)",
             n_checked, n_warned, n_held);
    $display("across %0d tilt limit settings including 0 and %0d.", PHASES + 1, ANGLE_MAX);
    if (errors == 0 && tilt_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tat_pkg.sv
hw/rtl/tat_sqrt.sv
hw/rtl/tat_cordic.sv
hw/rtl/accel_tilt_angle_warning_unit.sv
dv/tb_accel_tilt_angle_warning_unit.sv
